// File: rtl/assert_macros.svh
// Assertion macros used by the checker file rtl/dpv_assert.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/dpv_pkg.sv
// Types, constants and codes for the packet validator.
`timescale 1ns / 1ps
`default_nettype none
package dpv_pkg;

   localparam int MAX_BYTES   = 4096;
   localparam int POS_W       = $clog2(MAX_BYTES + 1);
   localparam int BYTE_CNT_W  = 13;

   localparam logic [7:0] SYNC_HI = 8'hF5;
   localparam logic [7:0] SYNC_LO = 8'hFA;

   localparam int POS_SYNC_HI = 0;
   localparam int POS_SYNC_LO = 1;
   localparam int POS_CMD_HI  = 2;
   localparam int POS_CMD_LO  = 3;
   localparam int POS_LEN_HI  = 4;
   localparam int POS_LEN_LO  = 5;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                  packet_ok;
      logic [1:0]            error_code;
      logic [15:0]           command_word;
      logic [15:0]           length_word;
      logic [BYTE_CNT_W-1:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } verdict_type;

endpackage
`default_nettype wire

// File: rtl/detector_packet_validator_core.sv
// Top level of the sync-header / checksum datagram validator.
//
//  channel | dir | struct   | transfer
//  req_    | in  | req_type | one datagram byte, last_byte on the final one
//  rsp_    | out | rsp_type | one verdict per datagram
//
//  One byte per cycle sustained, except while a final byte waits for queue space;
//  each byte passes through the input register. A final byte's verdict enters a
//  two-entry queue when that byte is taken from the register, which sets rsp_valid.
//  Bytes keep flowing while verdicts wait; a final byte holds in the input register
//  while the queue is full, which drops req_ready until a verdict is transferred.
//  Synchronous active-high reset clears all datagram state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module detector_packet_validator_core
   import dpv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic        held_valid;
   req_type     held_data;
   logic        take;
   logic        space;
   verdict_type verdict;

   assign take = held_valid && (!held_data.last_byte || space);

   dpv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (take),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   dpv_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .byte_data (held_data),
      .verdict   (verdict)
   );

   dpv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .verdict   (verdict),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/dpv_in_reg.sv
// Input holding register for received bytes.
`timescale 1ns / 1ps
`default_nettype none
module dpv_in_reg
   import dpv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    take,
   output logic         held_valid,
   output req_type      held_data
);

   logic    valid_ff, valid_in;
   req_type data_ff,  data_in;

   assign req_ready  = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// File: rtl/dpv_frame.sv
// Per-datagram state: sync check, running sum, field capture and verdict.
`timescale 1ns / 1ps
`default_nettype none
module dpv_frame
   import dpv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    take,
   input  wire req_type byte_data,
   output verdict_type  verdict
);

   logic [15:0]      sum_ff,    sum_in;
   logic [7:0]       prev_ff,   prev_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic             hdr_ff,    hdr_in;
   logic [15:0]      cmd_ff,    cmd_in;
   logic [15:0]      len_ff,    len_in;

   logic [POS_W-1:0] count;
   logic             two_plus;
   logic [15:0]      body;
   logic [15:0]      check;
   logic [15:0]      total;
   logic             hdr_ok;
   logic [7:0]       b;

   always_comb begin
      b        = byte_data.data_byte;
      count    = (pos_ff < POS_W'(MAX_BYTES)) ? pos_ff + POS_W'(1) : POS_W'(MAX_BYTES);
      two_plus = count >= POS_W'(2);

      hdr_in = hdr_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      if (pos_ff == POS_W'(POS_SYNC_HI) && b != SYNC_HI) hdr_in = 1'b0;
      if (pos_ff == POS_W'(POS_SYNC_LO) && b != SYNC_LO) hdr_in = 1'b0;
      if (pos_ff == POS_W'(POS_CMD_HI)) cmd_in = cmd_ff | {b, 8'h00};
      if (pos_ff == POS_W'(POS_CMD_LO)) cmd_in = cmd_ff | {8'h00, b};
      if (pos_ff == POS_W'(POS_LEN_HI)) len_in = len_ff | {b, 8'h00};
      if (pos_ff == POS_W'(POS_LEN_LO)) len_in = len_ff | {8'h00, b};

      hdr_ok = hdr_in && two_plus;
      if (two_plus) begin
         body  = sum_ff - {8'h00, prev_ff};
         check = {prev_ff, b};
      end else begin
         body  = 16'h0000;
         check = {8'h00, b};
      end
      total = body + check;

      verdict.valid             = take && byte_data.last_byte;
      verdict.data.command_word = cmd_in;
      verdict.data.length_word  = len_in;
      verdict.data.byte_count   = BYTE_CNT_W'(count);
      if (!hdr_ok) begin
         verdict.data.error_code = ERR_HEADER;
      end else if (total != 16'h0000) begin
         verdict.data.error_code = ERR_CHECKSUM;
      end else begin
         verdict.data.error_code = ERR_NONE;
      end
      verdict.data.packet_ok = (verdict.data.error_code == ERR_NONE);

      sum_in  = sum_ff + {8'h00, b};
      prev_in = b;
      pos_in  = count;
      if (byte_data.last_byte) begin
         sum_in  = 16'h0000;
         prev_in = 8'h00;
         pos_in  = '0;
         hdr_in  = 1'b1;
         cmd_in  = 16'h0000;
         len_in  = 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= 16'h0000;
         prev_ff <= 8'h00;
         pos_ff  <= '0;
         hdr_ff  <= 1'b1;
         cmd_ff  <= 16'h0000;
         len_ff  <= 16'h0000;
      end else if (take) begin
         sum_ff  <= sum_in;
         prev_ff <= prev_in;
         pos_ff  <= pos_in;
         hdr_ff  <= hdr_in;
         cmd_ff  <= cmd_in;
         len_ff  <= len_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/dpv_rsp_queue.sv
// Two-entry result register queue feeding the response channel.
`timescale 1ns / 1ps
`default_nettype none
module dpv_rsp_queue
   import dpv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire verdict_type verdict,
   output logic             space,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff,    cnt_in;
   logic       push, pop;

   assign space     = cnt_ff != 2'd2;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      push      = verdict.valid;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= verdict.data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/dpv_assert.sv
// Port-level checks on the validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dpv_assert
   import dpv_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic code_legal;
   logic ok_agrees;
   logic one_byte;
   logic hdr_err;

   assign code_legal = (rsp_data.error_code == ERR_NONE) ||
                       (rsp_data.error_code == ERR_HEADER) ||
                       (rsp_data.error_code == ERR_CHECKSUM);
   assign ok_agrees  = rsp_data.packet_ok == (rsp_data.error_code == ERR_NONE);
   assign one_byte   = rsp_data.byte_count == BYTE_CNT_W'(1);
   assign hdr_err    = rsp_data.error_code == ERR_HEADER;

   `CHK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data))
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `CHK_IMPLY(a_ok_matches_code, clock, reset, rsp_valid, ok_agrees)
   `CHK_IMPLY(a_code_legal, clock, reset, rsp_valid, code_legal)
   `CHK_IMPLY(a_single_byte_hdr, clock, reset, rsp_valid && one_byte, hdr_err)

endmodule

bind detector_packet_validator_core dpv_assert u_dpv_assert (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: verif/detector_packet_validator_core_tb.sv
// Self-checking testbench for the sync-header / checksum datagram validator.
`timescale 1ns / 1ps
module detector_packet_validator_core_tb;
   import dpv_pkg::*;

   localparam int RANDOM_BYTES = 1900;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic [7:0] byte_list_type[$];
   typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SYNC, FRAME_NOISE} frame_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   detector_packet_validator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   req_type     byte_feed[$];
   rsp_type     pending_verdicts[$];
   logic        req_taken = 1'b0;
   logic        hold_off = 1'b0;
   int          burst_left = 8;
   int          gap_left = 0;
   int          cycle_no = 0;
   int          fail_count = 0;
   int          frames_sent = 0;
   int          bytes_taken = 0;
   int          ok_seen = 0;
   int          sync_err_seen = 0;
   int          sum_err_seen = 0;

   // predictor state for the datagram in flight
   logic [15:0] sum_acc = '0;
   logic [7:0]  prev_byte = '0;
   int unsigned byte_pos = 0;
   logic        sync_ok = 1'b1;
   logic [15:0] cmd_acc = '0;
   logic [15:0] len_acc = '0;

   task automatic predict_byte(input req_type r);
      int unsigned cnt;
      logic [15:0] body;
      logic [15:0] check;
      logic [15:0] total;
      rsp_type     v;
      cnt = (byte_pos < MAX_BYTES) ? byte_pos + 1 : MAX_BYTES;
      case (byte_pos)
         POS_SYNC_HI: if (r.data_byte != SYNC_HI) sync_ok = 1'b0;
         POS_SYNC_LO: if (r.data_byte != SYNC_LO) sync_ok = 1'b0;
         POS_CMD_HI:  cmd_acc[15:8] = r.data_byte;
         POS_CMD_LO:  cmd_acc[7:0] = r.data_byte;
         POS_LEN_HI:  len_acc[15:8] = r.data_byte;
         POS_LEN_LO:  len_acc[7:0] = r.data_byte;
         default: ;
      endcase
      if (!r.last_byte) begin
         sum_acc = sum_acc + r.data_byte;
         prev_byte = r.data_byte;
         byte_pos = cnt;
      end else begin
         if (cnt >= 2) begin
            body = sum_acc - prev_byte;
            check = {prev_byte, r.data_byte};
         end else begin
            body = '0;
            check = {8'h00, r.data_byte};
         end
         total = body + check;
         if (!(sync_ok && cnt >= 2)) v.error_code = ERR_HEADER;
         else if (total != 16'h0000) v.error_code = ERR_CHECKSUM;
         else v.error_code = ERR_NONE;
         v.packet_ok = (v.error_code == ERR_NONE);
         v.command_word = cmd_acc;
         v.length_word = len_acc;
         v.byte_count = cnt[BYTE_CNT_W-1:0];
         pending_verdicts.push_back(v);
         sum_acc = '0;
         prev_byte = '0;
         byte_pos = 0;
         sync_ok = 1'b1;
         cmd_acc = '0;
         len_acc = '0;
      end
   endtask

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      logic    bad;
      case (got.error_code)
         ERR_NONE:     ok_seen++;
         ERR_HEADER:   sync_err_seen++;
         ERR_CHECKSUM: sum_err_seen++;
         default: ;
      endcase
      if (pending_verdicts.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected verdict: ok=%0d err=%0d cmd=%h len=%h count=%0d",
                     got.packet_ok, got.error_code, got.command_word, got.length_word,
                     got.byte_count);
         return;
      end
      want = pending_verdicts.pop_front();
      bad = (got.packet_ok !== want.packet_ok) || (got.error_code !== want.error_code) ||
            (got.command_word !== want.command_word) ||
            (got.length_word !== want.length_word) || (got.byte_count !== want.byte_count);
      if (bad) begin
         fail_count++;
         if (fail_count <= 10)
            $display("verdict mismatch: expected ok=%0d err=%0d cmd=%h len=%h count=%0d, %s",
                     want.packet_ok, want.error_code, want.command_word, want.length_word,
                     want.byte_count, $sformatf("got ok=%0d err=%0d cmd=%h len=%h count=%0d",
                     got.packet_ok, got.error_code, got.command_word, got.length_word,
                     got.byte_count));
      end
   endtask

   // appends the big-endian checksum word that makes the byte sum plus that word zero
   function automatic byte_list_type sealed(input byte_list_type f);
      logic [15:0]   s;
      byte_list_type g;
      s = '0;
      g = f;
      foreach (f[i]) s = s + f[i];
      s = -s;
      g.push_back(s[15:8]);
      g.push_back(s[7:0]);
      return g;
   endfunction

   task automatic add_frame(input byte_list_type f);
      req_type r;
      foreach (f[i]) begin
         r.data_byte = f[i];
         r.last_byte = (i == f.size() - 1);
         byte_feed.push_back(r);
      end
      frames_sent++;
   endtask

   task automatic add_random_frame(input int len, input frame_kind_type kind);
      byte_list_type f;
      logic [7:0]    flip;
      flip = 8'($urandom_range(1, 255));
      if (kind == FRAME_NOISE) begin
         if ($urandom_range(0, 2) == 0) begin
            f.push_back(SYNC_HI);
            f.push_back(SYNC_LO);
         end
         while (f.size() < len) f.push_back(8'($urandom));
      end else begin
         f.push_back(SYNC_HI);
         f.push_back(SYNC_LO);
         while (f.size() < len - 2) f.push_back(8'($urandom));
         if (kind == FRAME_BAD_SYNC) f[$urandom_range(0, 1)] ^= flip;
         f = sealed(f);
         if (kind == FRAME_BAD_SUM) f[$urandom_range(2, len - 1)] ^= flip;
      end
      add_frame(f);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_feed.size() > 0) begin
            req_data <= byte_feed.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 24);
               gap_left = $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes with bits 8:7 of the cycle number
   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else case (cycle_no[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 0);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // long receiver hold-off so the verdict queue fills and backs up the input
   initial begin
      @(negedge reset);
      repeat (800) @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         bytes_taken++;
         predict_byte(req_data);
      end
      if (!reset && rsp_valid && rsp_ready) check_verdict(rsp_data);
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (cycle_no > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_no);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      byte_list_type  f;
      int             pick;
      frame_kind_type kind;
      f = '{SYNC_HI};
      add_frame(f);
      f = '{SYNC_HI, SYNC_LO};
      add_frame(f);
      f = '{SYNC_HI, SYNC_LO, 8'h12};
      add_frame(f);
      f = '{SYNC_HI, SYNC_LO, 8'hFF, 8'hFF, 8'hFF};
      add_frame(sealed(f));
      f = '{SYNC_HI, SYNC_LO, 8'h00, 8'h00};
      add_frame(sealed(f));
      f = '{8'h00, SYNC_LO, 8'h01, 8'h02, 8'h03};
      add_frame(f);
      f = '{SYNC_HI, 8'hFB, 8'h80, 8'h01};
      add_frame(sealed(f));

      while (byte_feed.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 65) ? FRAME_GOOD : (pick < 80) ? FRAME_BAD_SUM :
                (pick < 92) ? FRAME_BAD_SYNC : FRAME_NOISE;
         if (kind == FRAME_NOISE) add_random_frame($urandom_range(1, 12), kind);
         else if ($urandom_range(0, 9) == 0) add_random_frame($urandom_range(25, 200), kind);
         else add_random_frame($urandom_range(4, 24), kind);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (byte_feed.size() > 0 || req_valid) @(posedge clock);
      while (pending_verdicts.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (pending_verdicts.size() > 0) begin
         $display("%0d verdicts never arrived", pending_verdicts.size());
         fail_count += pending_verdicts.size();
      end
      $display("%0d frames, %0d bytes transferred in %0d cycles", frames_sent, bytes_taken,
               cycle_no);
      $display("verdicts: %0d good, %0d sync errors, %0d checksum errors, %0d failures",
               ok_seen, sync_err_seen, sum_err_seen, fail_count);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
